>>> rtl/core/sorted_unique_id_set_assert.svh
// Assertion macros for the sorted identifier set.
`ifndef SORTED_UNIQUE_ID_SET_ASSERT_SVH
`define SORTED_UNIQUE_ID_SET_ASSERT_SVH
`ifndef ASSERT_OFF
`define SUIS_ASSERT(label, clk, rst_n, prop) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("suis assertion failed");
`define SUIS_ASSERT_ALWAYS(label, clk, prop) \
  label: assert property (@(posedge clk) prop) \
    else $error("suis assertion failed");
`else
`define SUIS_ASSERT(label, clk, rst_n, prop)
`define SUIS_ASSERT_ALWAYS(label, clk, prop)
`endif
`endif

>>> rtl/core/suis_pkg.sv
// Package: sizes, request codes and cell command type of the identifier set.
`default_nettype none
package suis_pkg;
  localparam int unsigned TABLE_DEPTH = 64;
  localparam int unsigned ID_W        = 32;
  localparam int unsigned CNT_W       = $clog2(TABLE_DEPTH + 1);
  localparam int unsigned ENTRIES_W   = 7;
  localparam int unsigned REQ_TYPE_W  = 2;

  typedef enum logic [REQ_TYPE_W-1:0] {
    REQ_INSERT = 2'd0,
    REQ_REMOVE = 2'd1,
    REQ_LOOKUP = 2'd2
  } req_type_e;

  typedef struct packed {
    logic ins_en;
    logic rem_en;
  } cell_cmd_t;
endpackage
`default_nettype wire

>>> rtl/core/suis_if.sv
// Request and result channel interfaces of the identifier set.
`default_nettype none
interface suis_req_if;
  logic                              valid;
  logic                              ready;
  logic [suis_pkg::REQ_TYPE_W-1:0]   req_type;
  logic [suis_pkg::ID_W-1:0]         ident;
  modport source (output valid, output req_type, output ident, input ready);
  modport sink   (input valid, input req_type, input ident, output ready);
endinterface

interface suis_res_if;
  logic                             valid;
  logic                             ready;
  logic                             hit;
  logic                             full_res;
  logic [suis_pkg::ENTRIES_W-1:0]   entries;
  modport source (output valid, output hit, output full_res, output entries, input ready);
  modport sink   (input valid, input hit, input full_res, input entries, output ready);
endinterface
`default_nettype wire

>>> rtl/core/suis_cell.sv
// One table cell: holds an identifier, compares it and shifts with its neighbors.
`default_nettype none
module suis_cell (
  input  wire logic                         clk_i,
  input  wire suis_pkg::cell_cmd_t          cmd_i,
  input  wire logic [suis_pkg::ID_W-1:0]    key_i,
  input  wire logic                         occ_i,
  input  wire logic                         left_slot_i,
  input  wire logic [suis_pkg::ID_W-1:0]    left_id_i,
  input  wire logic [suis_pkg::ID_W-1:0]    right_id_i,
  output logic [suis_pkg::ID_W-1:0]         id_o,
  output logic                              slot_o,
  output logic                              eq_o
);
  logic [suis_pkg::ID_W-1:0] id_q, id_d;
  logic                      id_we;

  // slot: this cell is at or after the sorted position of the key
  assign slot_o = !occ_i || (id_q >= key_i);
  assign eq_o   = occ_i && (id_q == key_i);
  assign id_o   = id_q;

  always_comb begin
    id_d  = id_q;
    id_we = 1'b0;
    if (cmd_i.ins_en && slot_o) begin
      id_we = 1'b1;
      id_d  = left_slot_i ? left_id_i : key_i;
    end else if (cmd_i.rem_en && slot_o) begin
      id_we = 1'b1;
      id_d  = right_id_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (id_we) begin
      id_q <= id_d;
    end
  end
endmodule
`default_nettype wire

>>> rtl/core/sorted_unique_id_set.sv
// Top level of the sorted identifier set: cell chain, count and result register.
// A set of up to TABLE_DEPTH 32-bit identifiers, kept in ascending order
// without duplicates in a chain of cells. A request (insert, remove or
// lookup) is handled in parallel: every cell compares its identifier with the
// key at once, the first cell not below the key marks the sorted position,
// and on insert the cells from there on shift one place up while on remove
// they shift one place down, all in the same clock. The result (hit, full
// flag, entry count after the request) sits in an output register and is
// shown the cycle after the request is taken. One request per cycle is
// sustained; the block takes a new request whenever the output register is
// empty or its result is being taken. Only cells below the entry count take
// part in a compare, so the table needs no clearing after reset. Request
// type 3 is ignored and answered with hit 0, full 0.
`default_nettype none
`include "sorted_unique_id_set_assert.svh"
module sorted_unique_id_set (
  input  wire logic   clk_i,
  input  wire logic   rst_ni,
  suis_req_if.sink    req_i,
  suis_res_if.source  res_o
);
  localparam int unsigned Depth = suis_pkg::TABLE_DEPTH;

  logic [suis_pkg::CNT_W-1:0]             count_q, count_d;
  logic [Depth-1:0][suis_pkg::ID_W-1:0]   cell_id;
  logic [Depth-1:0]                       cell_slot;
  logic [Depth-1:0]                       cell_eq;
  logic [Depth-1:0]                       cell_occ;
  logic                                   present;
  logic                                   accept;
  logic                                   hit_d, full_d;
  suis_pkg::cell_cmd_t                    cmd;

  logic                                   res_valid_q;
  logic                                   res_hit_q, res_full_q;
  logic [suis_pkg::ENTRIES_W-1:0]         res_entries_q;

  assign req_i.ready = !res_valid_q || res_o.ready;
  assign accept      = req_i.valid && req_i.ready;
  assign present     = |cell_eq;

  // Cell chain
  for (genvar i = 0; i < Depth; i++) begin : g_cell
    logic                      left_slot;
    logic [suis_pkg::ID_W-1:0] left_id, right_id;

    assign cell_occ[i] = suis_pkg::CNT_W'(i) < count_q;

    if (i == 0) begin : g_first
      assign left_slot = 1'b0;
      assign left_id   = req_i.ident;
    end else begin : g_mid
      assign left_slot = cell_slot[i-1];
      assign left_id   = cell_id[i-1];
    end

    if (i == Depth - 1) begin : g_last
      assign right_id = cell_id[i];
    end else begin : g_inner
      assign right_id = cell_id[i+1];
    end

    suis_cell u_cell (
      .clk_i       (clk_i),
      .cmd_i       (cmd),
      .key_i       (req_i.ident),
      .occ_i       (cell_occ[i]),
      .left_slot_i (left_slot),
      .left_id_i   (left_id),
      .right_id_i  (right_id),
      .id_o        (cell_id[i]),
      .slot_o      (cell_slot[i]),
      .eq_o        (cell_eq[i])
    );
  end

  // Request decode
  always_comb begin
    cmd     = '0;
    hit_d   = 1'b0;
    full_d  = 1'b0;
    count_d = count_q;
    unique case (req_i.req_type)
      suis_pkg::REQ_INSERT: begin
        if (!present) begin
          if (count_q == suis_pkg::CNT_W'(Depth)) begin
            full_d = 1'b1;
          end else begin
            cmd.ins_en = accept;
            hit_d      = 1'b1;
            count_d    = count_q + suis_pkg::CNT_W'(1);
          end
        end
      end
      suis_pkg::REQ_REMOVE: begin
        if (present) begin
          cmd.rem_en = accept;
          hit_d      = 1'b1;
          count_d    = count_q - suis_pkg::CNT_W'(1);
        end
      end
      suis_pkg::REQ_LOOKUP: begin
        hit_d = present;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q     <= '0;
      res_valid_q <= 1'b0;
    end else begin
      if (accept) begin
        count_q     <= count_d;
        res_valid_q <= 1'b1;
      end else if (res_o.ready) begin
        res_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      res_hit_q     <= hit_d;
      res_full_q    <= full_d;
      res_entries_q <= suis_pkg::ENTRIES_W'(count_d);
    end
  end

  assign res_o.valid    = res_valid_q;
  assign res_o.hit      = res_hit_q;
  assign res_o.full_res = res_full_q;
  assign res_o.entries  = res_entries_q;

  // Checks
  `SUIS_ASSERT(a_count_bound, clk_i, rst_ni, count_q <= suis_pkg::CNT_W'(Depth))
  `SUIS_ASSERT(a_hit_full_excl, clk_i, rst_ni, res_valid_q |-> !(res_hit_q && res_full_q))
  `SUIS_ASSERT(a_ins_count, clk_i, rst_ni, cmd.ins_en |=> count_q == $past(count_q) + 1'b1)
  `SUIS_ASSERT(a_cmd_excl, clk_i, rst_ni, !(cmd.ins_en && cmd.rem_en))
endmodule
`default_nettype wire
